// ===== hw/rtl/i2c_master_write_pin_sequencer_unit_macros.svh =====
// Assertion macros for the checker file of the I2C write pin sequencer.
// No dependencies; include with the bare file name.
`ifndef I2C_MASTER_WRITE_PIN_SEQUENCER_UNIT_MACROS_SVH
`define I2C_MASTER_WRITE_PIN_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define I2CW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cw same-cycle check failed");

// Next-cycle implication, off while reset is high
`define I2CW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cw next-cycle check failed");

// Next-cycle implication that also holds through reset
`define I2CW_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("i2cw reset check failed");

`endif

// ===== hw/rtl/i2cw_pkg.sv =====
// Shared types and constants of the I2C master write pin sequencer.
// No dependencies; used by the front, back and top-level RTL files of the block.
package i2cw_pkg;

  // Default queue depths
  localparam int CMD_DEPTH_DEF = 2;
  localparam int RES_DEPTH_DEF = 2;

  // Command codes
  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_SEND  = 2'd1,
    OP_END   = 2'd2
  } op_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_BYTE  = 4'b0100,
    ST_STOP  = 4'b1000
  } state_t;

  // Bit index of the acknowledge clock, last phase of a bit, last phase of start/stop
  localparam logic [3:0] ACK_BIT   = 4'd8;
  localparam logic [1:0] PH_BIT_END = 2'd2;
  localparam logic [1:0] PH_RUN_END = 2'd3;

  // Queued command
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  // One pin write
  typedef struct packed {
    logic scl;
    logic sda;
    logic hold;
    logic last;
  } res_t;

endpackage

// ===== hw/rtl/i2cw_fifo.sv =====
// Small register-based FIFO with full/empty flags.
// No dependencies; holds commands and pin writes of the sequencer.
module i2cw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/i2cw_front.sv =====
// Front end: holds the address register, accepts and classifies commands.
// Depends on i2cw_pkg.
module i2cw_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      opcode,
  input  logic [7:0]      data_byte,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  input  logic            cmd_full,
  output logic            cmd_wr,
  output i2cw_pkg::cmd_t  cmd_data
);

  logic [7:0] address_byte;
  logic       op_known;

  // Address register
  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte <= '0;
    end else if (cfg_we) begin
      address_byte <= cfg_wdata;
    end
  end

  // Classify: unknown opcode is accepted and dropped
  assign op_known = (opcode == 2'(i2cw_pkg::OP_BEGIN)) ||
                    (opcode == 2'(i2cw_pkg::OP_SEND))  ||
                    (opcode == 2'(i2cw_pkg::OP_END));

  assign full   = cmd_full;
  assign cmd_wr = push && !cmd_full && op_known;

  // Begin carries the address byte, send its payload
  always_comb begin
    cmd_data.op   = i2cw_pkg::op_t'(opcode);
    cmd_data.data = (opcode == 2'(i2cw_pkg::OP_BEGIN)) ? address_byte : data_byte;
  end

endmodule

// ===== hw/rtl/i2cw_back.sv =====
// Back end: pin sequencer, one pin write per cycle for the queued command while the result queue is not full.
// Depends on i2cw_pkg.
module i2cw_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_empty,
  input  i2cw_pkg::cmd_t  cmd_data,
  output logic            cmd_pop,
  input  logic            res_full,
  output logic            res_wr,
  output i2cw_pkg::res_t  res_data
);

  i2cw_pkg::state_t state, state_next;
  logic [1:0] ph, ph_next;
  logic [3:0] bc, bc_next;
  logic [7:0] sh, sh_next;
  logic       clock_line;
  logic       bit_val;
  logic       emit;
  logic       load;

  assign bit_val = (bc == i2cw_pkg::ACK_BIT) ? 1'b1 : sh[7];

  // Pin write for the current step
  always_comb begin
    res_data = '0;
    unique case (state)
      i2cw_pkg::ST_START: begin
        unique case (ph)
          2'd0:    res_data = '{scl: clock_line, sda: 1'b1, hold: 1'b0, last: 1'b0};
          2'd1:    res_data = '{scl: 1'b1, sda: 1'b1, hold: 1'b1, last: 1'b0};
          2'd2:    res_data = '{scl: 1'b1, sda: 1'b0, hold: 1'b1, last: 1'b0};
          default: res_data = '{scl: 1'b0, sda: 1'b0, hold: 1'b1, last: 1'b0};
        endcase
      end
      i2cw_pkg::ST_BYTE: begin
        unique case (ph)
          2'd0:    res_data = '{scl: clock_line, sda: bit_val, hold: 1'b1, last: 1'b0};
          2'd1:    res_data = '{scl: 1'b1, sda: bit_val, hold: 1'b1, last: 1'b0};
          default: res_data = '{scl: 1'b0, sda: bit_val,
                                hold: (bc == i2cw_pkg::ACK_BIT),
                                last: (bc == i2cw_pkg::ACK_BIT)};
        endcase
      end
      i2cw_pkg::ST_STOP: begin
        unique case (ph)
          2'd0:    res_data = '{scl: clock_line, sda: 1'b0, hold: 1'b0, last: 1'b0};
          2'd1:    res_data = '{scl: 1'b0, sda: 1'b0, hold: 1'b1, last: 1'b0};
          2'd2:    res_data = '{scl: 1'b1, sda: 1'b0, hold: 1'b1, last: 1'b0};
          default: res_data = '{scl: 1'b1, sda: 1'b1, hold: 1'b0, last: 1'b1};
        endcase
      end
      default: res_data = '0;
    endcase
  end

  // Handshake with both queues; next command loads when idle or on the last write
  assign emit    = (state != i2cw_pkg::ST_IDLE) && !res_full;
  assign res_wr  = emit;
  assign load    = !cmd_empty && ((state == i2cw_pkg::ST_IDLE) || (emit && res_data.last));
  assign cmd_pop = load;

  // Step sequencing
  always_comb begin
    state_next = state;
    ph_next    = ph;
    bc_next    = bc;
    sh_next    = sh;
    if (emit) begin
      unique case (state)
        i2cw_pkg::ST_START: begin
          if (ph == i2cw_pkg::PH_RUN_END) begin
            state_next = i2cw_pkg::ST_BYTE;
            ph_next    = '0;
            bc_next    = '0;
          end else begin
            ph_next = ph + 1'b1;
          end
        end
        i2cw_pkg::ST_BYTE: begin
          if (ph == i2cw_pkg::PH_BIT_END) begin
            ph_next = '0;
            bc_next = bc + 1'b1;
            sh_next = {sh[6:0], 1'b0};
            if (bc == i2cw_pkg::ACK_BIT) begin
              state_next = i2cw_pkg::ST_IDLE;
            end
          end else begin
            ph_next = ph + 1'b1;
          end
        end
        i2cw_pkg::ST_STOP: begin
          ph_next = ph + 1'b1;
          if (ph == i2cw_pkg::PH_RUN_END) begin
            state_next = i2cw_pkg::ST_IDLE;
          end
        end
        default: state_next = i2cw_pkg::ST_IDLE;
      endcase
    end
    if (load) begin
      ph_next = '0;
      bc_next = '0;
      sh_next = cmd_data.data;
      unique case (cmd_data.op)
        i2cw_pkg::OP_BEGIN: state_next = i2cw_pkg::ST_START;
        i2cw_pkg::OP_SEND:  state_next = i2cw_pkg::ST_BYTE;
        i2cw_pkg::OP_END:   state_next = i2cw_pkg::ST_STOP;
        default:            state_next = i2cw_pkg::ST_IDLE;
      endcase
    end
  end

  // Control state and line tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= i2cw_pkg::ST_IDLE;
      clock_line <= 1'b1;
    end else begin
      state <= state_next;
      if (emit) begin
        clock_line <= res_data.scl;
      end
    end
  end

  // Step counters and shift register
  always_ff @(posedge clk) begin
    ph <= ph_next;
    bc <= bc_next;
    sh <= sh_next;
  end

endmodule

// ===== hw/rtl/i2c_master_write_pin_sequencer_unit.sv =====
// I2C master write pin sequencer: begin gives 31 pin writes, send 27, end 4.
// One pin write per cycle from the back-end sequencer while the result queue is not
// full; a command occupies it for exactly its run length, a queued next command follows without a gap.
// The first result passes the command queue, sequencer state and result queue registers.
// Synchronous reset: queues empty, sequencer idle, tracked clock line high, address byte 0.
module i2c_master_write_pin_sequencer_unit #(
  parameter int CMD_DEPTH = i2cw_pkg::CMD_DEPTH_DEF,
  parameter int RES_DEPTH = i2cw_pkg::RES_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] opcode,
  input  logic [7:0] data_byte,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output logic       empty,
  input  logic       pop,
  output logic       scl_level,
  output logic       sda_level,
  output logic       hold_after,
  output logic       last_of_run
);

  logic           cmd_full;
  logic           cmd_wr;
  i2cw_pkg::cmd_t cmd_in;
  i2cw_pkg::cmd_t cmd_out;
  logic           cmd_empty;
  logic           cmd_pop;
  logic           res_full;
  logic           res_wr;
  i2cw_pkg::res_t res_in;
  i2cw_pkg::res_t res_out;

  // Command intake
  i2cw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .opcode    (opcode),
    .data_byte (data_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_full  (cmd_full),
    .cmd_wr    (cmd_wr),
    .cmd_data  (cmd_in)
  );

  // Command queue between front and back
  i2cw_fifo #(
    .WIDTH ($bits(i2cw_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  // Pin sequencer
  i2cw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_wr    (res_wr),
    .res_data  (res_in)
  );

  // Result queue
  i2cw_fifo #(
    .WIDTH ($bits(i2cw_pkg::res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_wr),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign scl_level   = res_out.scl;
  assign sda_level   = res_out.sda;
  assign hold_after  = res_out.hold;
  assign last_of_run = res_out.last;

endmodule

// ===== hw/rtl/i2cw_checker.sv =====
// Port-level checks of the I2C write pin sequencer, bound to the top level.
// Depends on i2c_master_write_pin_sequencer_unit_macros.svh.
`include "i2c_master_write_pin_sequencer_unit_macros.svh"

module i2cw_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       scl_level,
  input logic       sda_level,
  input logic       hold_after,
  input logic       last_of_run
);

  // Reset leaves both queues empty
  `I2CW_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, empty && !full)
  // A waiting result is not withdrawn
  `I2CW_ASSERT_NEXT(a_result_stays, clk, rst, !empty && !pop, !empty)
  // Every command ends with the data line released
  `I2CW_ASSERT_IMPLY(a_last_sda_high, clk, rst, !empty && last_of_run, sda_level)
  // Byte runs end with clock low and a hold; stop ends with clock high and no hold
  `I2CW_ASSERT_IMPLY(a_last_shape, clk, rst, !empty && last_of_run, hold_after != scl_level)

endmodule

bind i2c_master_write_pin_sequencer_unit i2cw_checker u_i2cw_checker (.*);
